/* rtl/core/rail_fence_transposer_unit_defines.svh */
// Assertion helpers for the rail fence transposer.
// Each check is compiled out when SYNTH is defined.
`ifndef RAIL_FENCE_TRANSPOSER_UNIT_DEFINES_SVH
`define RAIL_FENCE_TRANSPOSER_UNIT_DEFINES_SVH

`ifndef SYNTH

// Property must hold on every clock edge outside reset.
`define RFT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define RFT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define RFT_ASSERT(lbl, clk, rst_n, prop, msg)
`define RFT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/core/rft_pkg.sv */
package rft_pkg;

    localparam int CHAR_W     = 8;
    localparam int RAIL_W     = 5;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RAIL_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE = 1'd1;

    // ASCII letter bounds
    localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'h5A;
    localparam logic [CHAR_W-1:0] LOWER_FIRST = 8'h61;
    localparam logic [CHAR_W-1:0] LOWER_LAST  = 8'h7A;

    // Position walker status toward the top level
    typedef struct packed {
        logic valid;
        logic last;
    } walk_ctl_t;

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        logic upper;
        logic lower;
        upper = (c >= UPPER_FIRST) && (c <= UPPER_LAST);
        lower = (c >= LOWER_FIRST) && (c <= LOWER_LAST);
        return upper || lower;
    endfunction

endpackage

/* rtl/core/rft_zigzag.sv */
// Walk the zigzag rail by rail: for each output slot s, give the message
// position k that lands there. One pair per cycle after start.
module rft_zigzag #(
    parameter int MAX_LEN = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [$clog2(MAX_LEN+1)-1:0]  n,
    input  logic [rft_pkg::RAIL_W-1:0]    rails,
    output rft_pkg::walk_ctl_t            walk_ctl,
    output logic [$clog2(MAX_LEN)-1:0]    slot,
    output logic [$clog2(MAX_LEN)-1:0]    pos
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = $clog2(MAX_LEN);
    // k plus one zigzag period must not wrap
    localparam int KW = $clog2(MAX_LEN + 64) + 1;

    logic                        active_reg, active_next;
    logic [rft_pkg::RAIL_W-1:0]  rail_reg, rail_next;
    logic [KW-1:0]               k_reg, k_next;
    logic [PW-1:0]               s_reg, s_next;
    logic                        alt_reg, alt_next;
    logic [CW-1:0]               n_reg, n_next;

    logic [KW-1:0] period;
    logic [KW-1:0] twice_rail;
    logic [KW-1:0] step;
    logic [KW-1:0] k_sum;
    logic          edge_rail;
    logic          is_last;

    // Step sizes along one rail
    always_comb
    begin
        period     = KW'({rails - 5'd1, 1'b0});
        twice_rail = KW'({rail_reg, 1'b0});
        edge_rail  = (rail_reg == '0) || (rail_reg == rails - 5'd1);
        if (edge_rail)
        begin
            step = period;
        end
        else if (alt_reg)
        begin
            step = twice_rail;
        end
        else
        begin
            step = period - twice_rail;
        end
        k_sum   = k_reg + step;
        is_last = (CW'(s_reg) + CW'(1)) == n_reg;
    end

    // Advance position; move to the next rail when this one runs out
    always_comb
    begin
        active_next = active_reg;
        rail_next   = rail_reg;
        k_next      = k_reg;
        s_next      = s_reg;
        alt_next    = alt_reg;
        n_next      = n_reg;
        if (start)
        begin
            active_next = 1'b1;
            rail_next   = '0;
            k_next      = '0;
            s_next      = '0;
            alt_next    = 1'b0;
            n_next      = n;
        end
        else if (active_reg)
        begin
            s_next = s_reg + PW'(1);
            if (is_last)
            begin
                active_next = 1'b0;
            end
            if (k_sum < KW'(n_reg))
            begin
                k_next   = k_sum;
                alt_next = !alt_reg;
            end
            else
            begin
                rail_next = rail_reg + 5'd1;
                k_next    = KW'(rail_reg + 5'd1);
                alt_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            rail_reg   <= '0;
            k_reg      <= '0;
            s_reg      <= '0;
            alt_reg    <= 1'b0;
            n_reg      <= '0;
        end
        else
        begin
            active_reg <= active_next;
            rail_reg   <= rail_next;
            k_reg      <= k_next;
            s_reg      <= s_next;
            alt_reg    <= alt_next;
            n_reg      <= n_next;
        end
    end

    assign walk_ctl.valid = active_reg;
    assign walk_ctl.last  = active_reg && is_last;
    assign slot           = s_reg;
    assign pos            = k_reg[PW-1:0];

endmodule

/* rtl/core/rail_fence_transposer_unit.sv */
// Letters load at one byte per cycle while not busy; the last byte starts emission.
// Encode: results are read from the letter memory at the walked positions, one
// letter per cycle. Decode: a permute pass writes the letters into a second
// memory, then a readout pass reads that memory back in order.
// Results are strobed for one cycle and cannot be stalled. busy is high
// from the last byte until the final result. Reset clears control state only.
`include "rail_fence_transposer_unit_defines.svh"

module rail_fence_transposer_unit #(
    parameter int MAX_LEN   = 64,
    parameter int MAX_RAILS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [rft_pkg::CHAR_W-1:0]          char_in,
    input  logic                                last_in,
    input  logic                                cfg_we,
    input  logic [rft_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rft_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                result_valid,
    output logic [rft_pkg::CHAR_W-1:0]          char_out,
    output logic                                empty_res,
    output logic                                overflowed,
    output logic                                last_out
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = $clog2(MAX_LEN);
    localparam int RAIL_CAP = (MAX_RAILS < 31) ? MAX_RAILS : 31;
    localparam logic [rft_pkg::RAIL_W-1:0] RAIL_CAP_V = rft_pkg::RAIL_W'(RAIL_CAP);
    localparam logic [rft_pkg::RAIL_W-1:0] RAIL_MIN   = 5'd2;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    // Configuration
    logic [rft_pkg::RAIL_W-1:0] rail_count_reg;
    logic                       decode_mode_reg;
    logic [rft_pkg::RAIL_W-1:0] eff_rails;

    // Control
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] j_reg, j_next;

    // Read-data stage
    logic          p1_valid_reg, p1_valid_next;
    logic          p1_last_reg, p1_last_next;
    logic [PW-1:0] p1_pos_reg, p1_pos_next;

    // Result registers
    logic                        res_valid_reg, res_valid_next;
    logic [rft_pkg::CHAR_W-1:0]  res_char_reg, res_char_next;
    logic                        res_empty_reg, res_empty_next;
    logic                        res_ovf_reg, res_ovf_next;
    logic                        res_last_reg, res_last_next;

    // Memories
    logic [rft_pkg::CHAR_W-1:0] letter_mem [MAX_LEN];
    logic [rft_pkg::CHAR_W-1:0] perm_mem   [MAX_LEN];
    logic [rft_pkg::CHAR_W-1:0] buf_rdata_reg;
    logic [rft_pkg::CHAR_W-1:0] perm_rdata_reg;
    logic [PW-1:0]              buf_raddr;
    logic                       buf_we;
    logic                       perm_we;

    // Walker
    rft_pkg::walk_ctl_t walk_ctl;
    logic [PW-1:0]      walk_slot;
    logic [PW-1:0]      walk_pos;
    logic               walk_start;

    logic accept;
    logic letter;
    logic room;
    logic [CW-1:0] fill_inc;

    assign accept   = start && !busy;
    assign letter   = rft_pkg::is_letter(char_in);
    assign room     = fill_reg < CW'(MAX_LEN);
    assign fill_inc = (letter && room) ? fill_reg + CW'(1) : fill_reg;
    assign buf_we   = accept && letter && room;

    // Clamp rail count into the supported range
    always_comb
    begin
        priority if (rail_count_reg < RAIL_MIN)
        begin
            eff_rails = RAIL_MIN;
        end
        else if (rail_count_reg > RAIL_CAP_V)
        begin
            eff_rails = RAIL_CAP_V;
        end
        else
        begin
            eff_rails = rail_count_reg;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rail_count_reg  <= 5'd2;
            decode_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rft_pkg::REG_RAIL_COUNT:  rail_count_reg  <= cfg_data;
                rft_pkg::REG_DECODE_MODE: decode_mode_reg <= cfg_data[0];
            endcase
        end
    end

    assign walk_start = accept && last_in && (fill_inc != '0);

    rft_zigzag #(
        .MAX_LEN (MAX_LEN)
    ) u_zigzag (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (walk_start),
        .n        (fill_inc),
        .rails    (eff_rails),
        .walk_ctl (walk_ctl),
        .slot     (walk_slot),
        .pos      (walk_pos)
    );

    // Encode reads the letter at the walked position, decode reads in slot order
    assign buf_raddr = decode_mode_reg ? walk_slot : walk_pos;
    assign perm_we   = (state_reg == S_WALK) && p1_valid_reg && decode_mode_reg;

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            letter_mem[fill_reg[PW-1:0]] <= char_in;
        end
        buf_rdata_reg <= letter_mem[buf_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (perm_we)
        begin
            perm_mem[p1_pos_reg] <= buf_rdata_reg;
        end
        perm_rdata_reg <= perm_mem[j_reg[PW-1:0]];
    end

    // Sequencer: load, walk, and for decode a readout pass
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        j_next         = j_reg;
        p1_valid_next  = 1'b0;
        p1_last_next   = 1'b0;
        p1_pos_next    = p1_pos_reg;
        res_valid_next = 1'b0;
        res_char_next  = res_char_reg;
        res_empty_next = 1'b0;
        res_ovf_next   = res_ovf_reg;
        res_last_next  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fill_next = fill_inc;
                    ovf_next  = ovf_reg || (letter && !room);
                    if (last_in)
                    begin
                        if (fill_inc == '0)
                        begin
                            // Empty message: single marker result
                            res_valid_next = 1'b1;
                            res_char_next  = '0;
                            res_empty_next = 1'b1;
                            res_ovf_next   = ovf_next;
                            res_last_next  = 1'b1;
                            ovf_next       = 1'b0;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                end
            end

            S_WALK:
            begin
                p1_valid_next = walk_ctl.valid;
                p1_last_next  = walk_ctl.last;
                p1_pos_next   = walk_pos;
                if (p1_valid_reg && !decode_mode_reg)
                begin
                    res_valid_next = 1'b1;
                    res_char_next  = buf_rdata_reg;
                    res_ovf_next   = ovf_reg;
                    res_last_next  = p1_last_reg;
                end
                if (p1_valid_reg && p1_last_reg)
                begin
                    if (decode_mode_reg)
                    begin
                        state_next = S_DRAIN;
                        j_next     = '0;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end

            S_DRAIN:
            begin
                // Issue reads of the permuted text in order
                if (j_reg < fill_reg)
                begin
                    p1_valid_next = 1'b1;
                    p1_last_next  = (j_reg + CW'(1)) == fill_reg;
                    j_next        = j_reg + CW'(1);
                end
                if (p1_valid_reg)
                begin
                    res_valid_next = 1'b1;
                    res_char_next  = perm_rdata_reg;
                    res_ovf_next   = ovf_reg;
                    res_last_next  = p1_last_reg;
                    if (p1_last_reg)
                    begin
                        state_next = S_IDLE;
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            j_reg         <= '0;
            p1_valid_reg  <= 1'b0;
            p1_last_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            res_empty_reg <= 1'b0;
            res_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            j_reg         <= j_next;
            p1_valid_reg  <= p1_valid_next;
            p1_last_reg   <= p1_last_next;
            res_valid_reg <= res_valid_next;
            res_empty_reg <= res_empty_next;
            res_last_reg  <= res_last_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        p1_pos_reg   <= p1_pos_next;
        res_char_reg <= res_char_next;
        res_ovf_reg  <= res_ovf_next;
    end

    assign busy         = state_reg != S_IDLE;
    assign result_valid = res_valid_reg;
    assign char_out     = res_char_reg;
    assign empty_res    = res_empty_reg;
    assign overflowed   = res_ovf_reg;
    assign last_out     = res_last_reg;

    // Checks
    `RFT_ASSERT(a_empty_is_last, clk, rst_n, (result_valid && empty_res) |-> last_out, "empty result not marked last")
    `RFT_ASSERT(a_busy_ends_on_last, clk, rst_n, $fell(busy) |-> (result_valid && last_out), "busy dropped without final result")
    `RFT_ASSERT_NEVER(a_walk_outside_state, clk, rst_n, walk_ctl.valid && (state_reg != S_WALK), "walker active outside walk state")
    `RFT_ASSERT_NEVER(a_drain_in_encode, clk, rst_n, (state_reg == S_DRAIN) && !decode_mode_reg, "readout pass in encode mode")

endmodule
